FILE: sv/rfdp_pkg.sv
`timescale 1ns / 1ps

package rfdp_pkg;

  // number of kept fraction digits, distance is scaled by ten to this power
  localparam int FRAC_DIGITS = 3;

  localparam logic [31:0] POW_TEN [8] = '{
    32'd1, 32'd10, 32'd100, 32'd1000,
    32'd10000, 32'd100000, 32'd1000000, 32'd10000000
  };

  localparam logic [31:0] FRAC_SCALE = POW_TEN[FRAC_DIGITS];
  localparam logic [31:0] DIST_MAX   = 32'h7FFF_FFFF;
  localparam int unsigned INT_CAP    = DIST_MAX / FRAC_SCALE;

  localparam int INT_W  = $clog2(INT_CAP + 1);
  localparam int FRAC_W = $clog2(FRAC_SCALE);
  localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);

  localparam logic [15:0] STATUS_MAX = 16'hFFFF;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_STAT_FIRST,
    PH_STAT,
    PH_TAIL_OK,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    logic              ok;
    logic              is_negative;
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [CNT_W-1:0]  frac_cnt;
    logic [15:0]       status_acc;
    logic              overflow_seen;
  } frame_snap_t;

endpackage

FILE: sv/rfdp_if.sv
`timescale 1ns / 1ps

interface rfdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfdp_result_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic signed [31:0] distance_milli;
  logic [15:0]        status_code;
  logic               saturated;

  modport source (
    output valid, output frame_ok, output distance_milli,
    output status_code, output saturated, input ready
  );
  modport sink (
    input valid, input frame_ok, input distance_milli,
    input status_code, input saturated, output ready
  );
endinterface

FILE: sv/range_frame_decimal_parser_core.sv
`timescale 1ns / 1ps

// ascii rangefinder frame parser: takes one byte per cycle of the form
// [-][digits][.fraction],status<anything>CR LF and, on the LF that follows a
// CR, delivers one result request with frame_ok, the signed distance in
// thousandths (extra fraction digits truncated), the status (clamped at
// 65535) and a saturated flag; a malformed frame gives frame_ok low and all
// other fields zero. every other byte gives no result. throughput is one
// byte per cycle; each byte passes through one input register, then the
// phase update or the final scale-and-clamp, then the result register. an
// end-of-frame byte waits in the input register only while an earlier
// result is still held at the output; all other bytes keep flowing
// regardless of output backpressure.

module range_frame_decimal_parser_core (
  input  logic          clk,
  input  logic          rst_n,
  rfdp_byte_if.sink     in_if,
  rfdp_result_if.source out_if
);
  import rfdp_pkg::*;

  byte_stage_t stage;
  frame_snap_t snap;
  logic        end_req;
  logic        out_free;
  logic        advance;

  // byte leaves the input register when it needs no result slot or the slot is free
  assign advance = stage.valid && (!end_req || out_free);

  rfdp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .advance (advance),
    .stage   (stage)
  );

  // frame phase and the integer, fraction and status accumulators
  rfdp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .end_req (end_req),
    .snap    (snap)
  );

  // scale, clamp, sign and hold the result request
  rfdp_result u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && end_req),
    .snap     (snap),
    .out_if   (out_if),
    .out_free (out_free)
  );

endmodule

FILE: sv/rfdp_in_stage.sv
`timescale 1ns / 1ps

module rfdp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  rfdp_byte_if.sink            in_if,
  input  logic                 advance,
  output rfdp_pkg::byte_stage_t stage
);
  import rfdp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       take;

  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;
  assign valid_nxt   = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_if.rx_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

FILE: sv/rfdp_parser.sv
`timescale 1ns / 1ps

module rfdp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rfdp_pkg::byte_stage_t stage,
  input  logic                  advance,
  output logic                  end_req,
  output rfdp_pkg::frame_snap_t snap
);
  import rfdp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic              neg_r;
  logic [INT_W-1:0]  int_r;
  logic [FRAC_W-1:0] frac_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              seen_r;
  logic [15:0]       stat_r;
  logic              ovf_r;
  logic              cr_r;

  logic              is_digit;
  logic [3:0]        digit;
  logic              add_int, add_frac, add_stat, set_neg;
  logic [INT_W+3:0]  int_next;
  logic [FRAC_W+3:0] frac_next;
  logic [19:0]       stat_next;
  logic              int_over, stat_over, frac_room;

  assign is_digit = (stage.data >= CH_ZERO) && (stage.data <= CH_NINE);
  assign digit    = stage.data[3:0];
  // lf right after cr closes the frame and needs a free result slot
  assign end_req  = stage.valid && (stage.data == CH_LF) && cr_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_START: begin
        if (stage.data == CH_MINUS || is_digit) phase_nxt = PH_INT;
        else if (stage.data == CH_POINT)        phase_nxt = PH_FRAC;
        else                                    phase_nxt = PH_ERROR;
      end
      PH_INT: begin
        if (is_digit)                                phase_nxt = PH_INT;
        else if (stage.data == CH_POINT)             phase_nxt = PH_FRAC;
        else if (stage.data == CH_COMMA && seen_r)   phase_nxt = PH_STAT_FIRST;
        else                                         phase_nxt = PH_ERROR;
      end
      PH_FRAC: begin
        if (is_digit)                                phase_nxt = PH_FRAC;
        else if (stage.data == CH_COMMA && seen_r)   phase_nxt = PH_STAT_FIRST;
        else                                         phase_nxt = PH_ERROR;
      end
      PH_STAT_FIRST: phase_nxt = is_digit ? PH_STAT : PH_ERROR;
      PH_STAT:       phase_nxt = is_digit ? PH_STAT : PH_TAIL_OK;
      PH_TAIL_OK:    phase_nxt = PH_TAIL_OK;
      default:       phase_nxt = PH_ERROR;
    endcase
  end

  // datapath actions per phase
  always_comb begin
    add_int  = 1'b0;
    add_frac = 1'b0;
    add_stat = 1'b0;
    set_neg  = 1'b0;
    unique case (phase_r)
      PH_START: begin
        set_neg = (stage.data == CH_MINUS);
        add_int = is_digit;
      end
      PH_INT:        add_int  = is_digit;
      PH_FRAC:       add_frac = is_digit;
      PH_STAT_FIRST: add_stat = is_digit;
      PH_STAT:       add_stat = is_digit;
      default: begin
      end
    endcase
  end

  assign int_next  = {4'b0, int_r} * (INT_W+4)'(10) + (INT_W+4)'(digit);
  assign int_over  = int_next > (INT_W+4)'(INT_CAP);
  assign frac_next = {4'b0, frac_r} * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
  assign frac_room = cnt_r < CNT_W'(FRAC_DIGITS);
  assign stat_next = {4'b0, stat_r} * 20'd10 + 20'(digit);
  assign stat_over = stat_next > {4'b0, STATUS_MAX};

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && end_req)) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      int_r   <= '0;
      frac_r  <= '0;
      cnt_r   <= '0;
      seen_r  <= 1'b0;
      stat_r  <= '0;
      ovf_r   <= 1'b0;
      cr_r    <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cr_r    <= (stage.data == CH_CR);
      if (set_neg) neg_r <= 1'b1;
      if (add_int) begin
        seen_r <= 1'b1;
        if (int_over) begin
          int_r <= INT_W'(INT_CAP);
          ovf_r <= 1'b1;
        end else begin
          int_r <= int_next[INT_W-1:0];
        end
      end
      if (add_frac) begin
        seen_r <= 1'b1;
        if (frac_room) begin
          frac_r <= frac_next[FRAC_W-1:0];
          cnt_r  <= cnt_r + CNT_W'(1);
        end
      end
      if (add_stat) begin
        if (stat_over) begin
          stat_r <= STATUS_MAX;
          ovf_r  <= 1'b1;
        end else begin
          stat_r <= stat_next[15:0];
        end
      end
    end
  end

  assign snap.ok            = (phase_r == PH_TAIL_OK) || (phase_r == PH_STAT);
  assign snap.is_negative   = neg_r;
  assign snap.int_acc       = int_r;
  assign snap.frac_acc      = frac_r;
  assign snap.frac_cnt      = cnt_r;
  assign snap.status_acc    = stat_r;
  assign snap.overflow_seen = ovf_r;

endmodule

FILE: sv/rfdp_result.sv
`timescale 1ns / 1ps

module rfdp_result (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  rfdp_pkg::frame_snap_t snap,
  rfdp_result_if.source         out_if,
  output logic                  out_free
);
  import rfdp_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  logic               ok_r;
  logic signed [31:0] dist_r;
  logic [15:0]        stat_r;
  logic               sat_r;

  logic [2:0]         idx;
  logic [31:0]        int_scaled;
  logic [31:0]        frac_scaled;
  logic [32:0]        mag;
  logic               clamp;
  logic [31:0]        mag_c;
  logic signed [31:0] dist_val;

  // fraction digits short of full count are scaled up to full precision
  assign idx         = 3'(FRAC_DIGITS) - 3'(snap.frac_cnt);
  assign int_scaled  = 32'(snap.int_acc) * FRAC_SCALE;
  assign frac_scaled = 32'(snap.frac_acc) * POW_TEN[idx];
  assign mag         = {1'b0, int_scaled} + {1'b0, frac_scaled};
  assign clamp       = mag > {1'b0, DIST_MAX};
  assign mag_c       = clamp ? DIST_MAX : mag[31:0];
  assign dist_val    = snap.is_negative ? -$signed(mag_c) : $signed(mag_c);

  assign out_free  = !valid_r || out_if.ready;
  assign valid_nxt = load ? 1'b1 : (out_if.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r   <= snap.ok;
      dist_r <= snap.ok ? dist_val : '0;
      stat_r <= snap.ok ? snap.status_acc : '0;
      sat_r  <= snap.ok && (snap.overflow_seen || clamp);
    end
  end

  assign out_if.valid          = valid_r;
  assign out_if.frame_ok       = ok_r;
  assign out_if.distance_milli = dist_r;
  assign out_if.status_code    = stat_r;
  assign out_if.saturated      = sat_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rfdp_pkg::*;

  localparam int RANDOM_BYTES   = 1570;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_DIR          = 20;

  typedef struct {
    logic               ok;
    logic signed [31:0] distance;
    logic [15:0]        stat;
    logic               sat;
  } frame_result_t;

  // one directed frame body; CR LF is appended when it is sent
  typedef struct {
    string body;
    bit    typed;
    bit    ok;
    int    distance;
    int    stat;
    bit    sat;
  } dir_row_t;

  dir_row_t dir_tab [N_DIR] = '{
    '{"0,0",               1, 1, 0,           0,     0},
    '{"2147483.647,65535", 1, 1, 2147483647,  65535, 0},
    '{"-2147483.647,0",    1, 1, -2147483647, 0,     0},
    '{"2147483.648,1",     1, 1, 2147483647,  1,     1},
    '{"99999999,65536",    1, 1, 2147483000,  65535, 1},
    '{"5,123456",          1, 1, 5000,        65535, 1},
    '{"-0.000,7",          1, 1, 0,           7,     0},
    '{"1.23456,12",        0, 0, 0,           0,     0},
    '{".5,9",              0, 0, 0,           0,     0},
    '{"-12.,300x",         0, 0, 0,           0,     0},
    '{"3.5,42 cm xyz",     0, 0, 0,           0,     0},
    '{"1,2\015\015",       0, 0, 0,           0,     0},
    '{",5",                1, 0, 0,           0,     0},
    '{"-,5",               1, 0, 0,           0,     0},
    '{".,5",               1, 0, 0,           0,     0},
    '{"12,",               1, 0, 0,           0,     0},
    '{"4\0155,1",          1, 0, 0,           0,     0},
    '{"7\012,3",           1, 0, 0,           0,     0},
    '{"\377,1",            1, 0, 0,           0,     0},
    '{"",                  1, 0, 0,           0,     0}
  };

  logic clk = 1'b0;
  logic rst_n;

  rfdp_byte_if   in_ch ();
  rfdp_result_if out_ch ();

  range_frame_decimal_parser_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #6 clk = ~clk;

  // parser mirror
  phase_t      p_phase;
  bit          p_neg, p_num, p_ovf, p_cr;
  int unsigned p_int, p_frac, p_cnt, p_stat;

  frame_result_t pending_frames [$];
  logic [7:0]    frame_bytes [$];

  bit            steady_in;
  bit            use_typed;
  frame_result_t typed_res;

  int mismatches   = 0;
  int results_seen = 0;
  int ok_seen      = 0;
  int sat_seen     = 0;
  int bytes_sent   = 0;
  int frames_sent  = 0;
  int stall_count  = 0;

  function automatic void clear_parser();
    p_phase = PH_START;
    p_neg   = 1'b0;
    p_int   = 0;
    p_frac  = 0;
    p_cnt   = 0;
    p_num   = 1'b0;
    p_stat  = 0;
    p_ovf   = 1'b0;
    p_cr    = 1'b0;
  endfunction

  function automatic void take_int_digit(input int unsigned d);
    longint unsigned nxt;
    nxt = p_int;
    nxt = nxt * 10 + d;
    if (nxt > INT_CAP) begin
      p_int = INT_CAP;
      p_ovf = 1'b1;
    end else begin
      p_int = int'(nxt);
    end
    p_num = 1'b1;
  endfunction

  function automatic void take_status_digit(input int unsigned d);
    longint unsigned nxt;
    nxt = p_stat;
    nxt = nxt * 10 + d;
    if (nxt > STATUS_MAX) begin
      p_stat = STATUS_MAX;
      p_ovf  = 1'b1;
    end else begin
      p_stat = int'(nxt);
    end
  endfunction

  // returns 1 when the byte closes a frame, with the frame's result in r
  function automatic bit parse_byte(input logic [7:0] c, output frame_result_t r);
    bit              is_dig;
    int unsigned     d;
    longint unsigned mag;
    is_dig     = (c >= CH_ZERO) && (c <= CH_NINE);
    d          = c - CH_ZERO;
    r.ok       = 1'b0;
    r.distance = '0;
    r.stat     = '0;
    r.sat      = 1'b0;
    if (c == CH_LF && p_cr) begin
      if (p_phase == PH_TAIL_OK || p_phase == PH_STAT) begin
        mag = p_int;
        mag = mag * FRAC_SCALE + p_frac * POW_TEN[FRAC_DIGITS - p_cnt];
        r.sat = p_ovf;
        if (mag > DIST_MAX) begin
          mag   = DIST_MAX;
          r.sat = 1'b1;
        end
        r.ok       = 1'b1;
        r.distance = p_neg ? -mag[31:0] : mag[31:0];
        r.stat     = p_stat[15:0];
      end
      clear_parser();
      return 1'b1;
    end
    case (p_phase)
      PH_START: begin
        if (c == CH_MINUS) begin
          p_neg   = 1'b1;
          p_phase = PH_INT;
        end else if (is_dig) begin
          take_int_digit(d);
          p_phase = PH_INT;
        end else if (c == CH_POINT) begin
          p_phase = PH_FRAC;
        end else begin
          p_phase = PH_ERROR;
        end
      end
      PH_INT: begin
        if (is_dig) take_int_digit(d);
        else if (c == CH_POINT) p_phase = PH_FRAC;
        else if (c == CH_COMMA && p_num) p_phase = PH_STAT_FIRST;
        else p_phase = PH_ERROR;
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (p_cnt < FRAC_DIGITS) begin
            p_frac = p_frac * 10 + d;
            p_cnt++;
          end
          p_num = 1'b1;
        end else if (c == CH_COMMA && p_num) begin
          p_phase = PH_STAT_FIRST;
        end else begin
          p_phase = PH_ERROR;
        end
      end
      PH_STAT_FIRST: begin
        if (is_dig) begin
          take_status_digit(d);
          p_phase = PH_STAT;
        end else begin
          p_phase = PH_ERROR;
        end
      end
      PH_STAT: begin
        if (is_dig) take_status_digit(d);
        else p_phase = PH_TAIL_OK;
      end
      PH_TAIL_OK: ;
      default: p_phase = PH_ERROR;
    endcase
    p_cr = (c == CH_CR);
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // mostly well-formed frames with random content, some corrupted, some noise
  task automatic build_frame();
    string    cap_s = "2147483";
    int       kind, pick, n_int, n_frac, n_stat, n_tail, pos;
    bit       point;
    logic [7:0] b;
    frame_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n_tail = $urandom_range(0, 12);
      repeat (n_tail) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) frame_bytes.push_back(CH_MINUS);
      pick  = $urandom_range(0, 9);
      point = $urandom_range(0, 1);
      if (pick == 0) n_int = 0;
      else if (pick <= 6) n_int = $urandom_range(1, 3);
      else if (pick == 7) n_int = $urandom_range(4, 7);
      else if (pick == 8) n_int = $urandom_range(8, 10);
      else n_int = -1;
      // integer part at the cap, fraction decides whether the magnitude clamps
      if (n_int < 0) begin
        for (int i = 0; i < cap_s.len(); i++) frame_bytes.push_back(cap_s[i]);
        point = 1'b1;
        n_int = 7;
      end else begin
        repeat (n_int) frame_bytes.push_back(rand_digit());
      end
      n_frac = point ? $urandom_range(0, 5) : 0;
      if (n_int == 0 && n_frac == 0) begin
        point  = 1'b1;
        n_frac = 1;
      end
      if (point) frame_bytes.push_back(CH_POINT);
      repeat (n_frac) frame_bytes.push_back(rand_digit());
      frame_bytes.push_back(CH_COMMA);
      n_stat = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 7);
      repeat (n_stat) frame_bytes.push_back(rand_digit());
      if ($urandom_range(0, 9) < 3) begin
        n_tail = $urandom_range(1, 4);
        repeat (n_tail) begin
          b = 8'($urandom_range(0, 255));
          frame_bytes.push_back(b == CH_CR ? 8'h20 : b);
        end
      end
      if (kind < 30) begin
        pos = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[pos] = 8'($urandom_range(0, 255));
      end
    end
    frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    frame_result_t r;
    while (!steady_in && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (parse_byte(b, r)) begin
      pending_frames.push_back(use_typed ? typed_res : r);
    end
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [32:0] e,
                             input logic signed [32:0] a);
    if (e !== a) begin
      mismatches++;
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
    end
  endtask

  // stimulus
  initial begin
    int rand_bytes;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    rst_n         = 1'b0;
    steady_in     = 1'b0;
    use_typed     = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIR; k++) begin
      use_typed          = dir_tab[k].typed;
      typed_res.ok       = dir_tab[k].ok;
      typed_res.distance = dir_tab[k].distance;
      typed_res.stat     = 16'(dir_tab[k].stat);
      typed_res.sat      = dir_tab[k].sat;
      for (int i = 0; i < dir_tab[k].body.len(); i++) send_byte(dir_tab[k].body[i]);
      send_byte(CH_CR);
      send_byte(CH_LF);
      frames_sent++;
    end
    use_typed = 1'b0;
    wait_results_drained();

    rand_bytes = 0;
    for (int f = 0; rand_bytes < RANDOM_BYTES; f++) begin
      build_frame();
      steady_in = (f >= 50) && (f < 80);
      if (f == 90) wait_results_drained();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
      rand_bytes += frame_bytes.size();
      frames_sent++;
    end
    steady_in = 1'b0;
    wait_results_drained();
    repeat (6) @(posedge clk);

    $display("sent %0d frames in %0d bytes, directed edge cases then random frames",
             frames_sent, bytes_sent);
    $display("checked %0d results: %0d well-formed, %0d clamped",
             results_seen, ok_seen, sat_seen);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, one stall-free stretch
  initial begin
    int  hold_left;
    bit  held;
    hold_left    = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 40) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= 100 && results_seen < 140) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // compare each result request with the oldest prediction
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_frames.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result frame_ok %0d distance %0d status %0d sat %0d",
                 $time, out_ch.frame_ok, out_ch.distance_milli, out_ch.status_code,
                 out_ch.saturated);
      end else begin
        exp_r = pending_frames.pop_front();
        if (exp_r.ok) ok_seen++;
        if (exp_r.sat) sat_seen++;
        check_field("frame_ok", 33'(exp_r.ok), 33'(out_ch.frame_ok));
        check_field("distance_milli", 33'(exp_r.distance), 33'(out_ch.distance_milli));
        check_field("status_code", 33'(exp_r.stat), 33'(out_ch.status_code));
        check_field("saturated", 33'(exp_r.sat), 33'(out_ch.saturated));
      end
    end
  end

  // no request moving on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles, %0d results outstanding",
                 $time, stall_count, pending_frames.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
sv/rfdp_pkg.sv
sv/rfdp_if.sv
sv/rfdp_in_stage.sv
sv/rfdp_parser.sv
sv/rfdp_result.sv
sv/range_frame_decimal_parser_core.sv
tb/testbench.sv
